FILE: src/assert_macros.svh
// assertion macros used by block_map_allocator
// no dependencies; included by block_map_allocator, the only file that carries concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held low
`define BMA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked during reset as well
`define BMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/bma_pkg.sv
// types and constants of the block map allocator
// no dependencies; imported by block_map_allocator
package bma_pkg;

    localparam int BYTES_W     = 14;
    localparam int OFS_W       = 14;
    localparam int STATUS_W    = 2;
    localparam int ALLOC_OFS_W = 13;
    localparam int PCT_OUT_W   = 7;
    localparam int PCT_SCALE   = 100;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

    typedef struct packed {
        logic               mode;
        logic [BYTES_W-1:0] request_bytes;
        logic [OFS_W-1:0]   free_offset;
    } t_bma_in;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ALLOC_OFS_W-1:0] alloc_offset;
        logic [PCT_OUT_W-1:0]   used_percent;
    } t_bma_out;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_OFS_DIV,
        S_FREE_HEAD,
        S_FREE_RUN,
        S_PCT_GO,
        S_PCT
    } t_state;

endpackage

FILE: src/bma_ram.sv
// generic single-write, single-read memory with a registered read port
// no dependencies
module bma_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bma_cdiv.sv
// division by a fixed divisor through reciprocal multiplication, quotient registered in the cycle after start
// no dependencies
module bma_cdiv #(
    parameter int DIVIDEND_W = 14,
    parameter int QUOT_W     = 14,
    parameter int DIVISOR    = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    output logic                  o_done,
    output logic [QUOT_W-1:0]     o_quot
);

    // rounded-up reciprocal, exact for every dividend below 2**DIVIDEND_W
    localparam int     SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
    localparam longint RECIP   = ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1))
                                 / longint'(DIVISOR);
    localparam int     RECIP_W = $clog2(RECIP + longint'(1));
    localparam int     PROD_W  = DIVIDEND_W + RECIP_W;

    logic              r_done, n_done;
    logic [QUOT_W-1:0] r_quot, n_quot;
    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(i_dividend) * PROD_W'(RECIP);

    always_comb begin
        n_done = i_start;
        n_quot = r_quot;
        if (i_start) begin
            n_quot = QUOT_W'(prod >> SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: src/block_map_allocator.sv
// channel   | ports                 | handshake
// request   | start, busy, i_item   | taken when start is high and busy is low
// result    | o_valid, o_result     | one-cycle strobe, cannot be held off
//
// allocate: map entries are scanned from the top block down to the run found
//   (all BLOCK_COUNT entries when nothing fits), then each block of the run is written
// free: offset division, then the head entry, then each further block of the run
// every transaction ends with the usage calculation (S_PCT_GO, then S_PCT); a zero size or an
//   out-of-range offset takes only that calculation; the strobe comes as busy drops
// after reset a clearing pass writes every map entry, busy high
// depends on bma_pkg, bma_ram, bma_cdiv and assert_macros.svh
`include "assert_macros.svh"
module block_map_allocator
    import bma_pkg::*;
#(
    parameter int BLOCK_BYTES = 32,
    parameter int BLOCK_COUNT = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_bma_in  i_item,
    output logic     o_valid,
    output t_bma_out o_result
);

    localparam int IDX_W      = $clog2(BLOCK_COUNT);
    localparam int LEN_W      = $clog2(BLOCK_COUNT + 1);
    localparam int POOL_BYTES = BLOCK_BYTES * BLOCK_COUNT;
    localparam int RB_W       = $clog2(POOL_BYTES + 1);
    localparam int CMP_W      = (RB_W > OFS_W) ? RB_W : OFS_W;
    localparam int PCT_W      = LEN_W + 7;

    t_state r_state, n_state;

    logic [LEN_W-1:0]       r_ptr, n_ptr;
    logic [LEN_W-1:0]       r_cnt, n_cnt;
    logic [LEN_W-1:0]       r_need, n_need;
    logic [LEN_W-1:0]       r_run, n_run;
    logic [LEN_W-1:0]       r_used, n_used;
    logic [RB_W-1:0]        r_rb, n_rb;
    t_bma_in                r_item, n_item;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [ALLOC_OFS_W-1:0] r_aofs, n_aofs;
    t_bma_out               r_result, n_result;
    logic                   r_valid, n_valid;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [LEN_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [LEN_W-1:0] ram_rdata;

    logic                 ofs_start;
    logic                 ofs_done;
    logic [OFS_W-1:0]     ofs_quot;
    logic                 pct_start;
    logic                 pct_done;
    logic [PCT_OUT_W-1:0] pct_quot;
    logic [PCT_W-1:0]     pct_dividend;

    logic             accept;
    logic             in_range;
    logic [LEN_W-1:0] run_next;
    logic [RB_W-1:0]  rb_next;
    logic             match;
    logic [LEN_W-1:0] cur_cnt;
    logic [LEN_W-1:0] ptr_inc;
    logic [LEN_W-1:0] ptr_dec;
    logic             free_last;
    logic             clear_last;

    bma_ram #(
        .WIDTH (LEN_W),
        .DEPTH (BLOCK_COUNT)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // block index of a byte offset
    bma_cdiv #(
        .DIVIDEND_W (OFS_W),
        .QUOT_W     (OFS_W),
        .DIVISOR    (BLOCK_BYTES)
    ) u_ofs_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ofs_start),
        .i_dividend (i_item.free_offset),
        .o_done     (ofs_done),
        .o_quot     (ofs_quot)
    );

    // usage in percent
    bma_cdiv #(
        .DIVIDEND_W (PCT_W),
        .QUOT_W     (PCT_OUT_W),
        .DIVISOR    (BLOCK_COUNT)
    ) u_pct_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (pct_start),
        .i_dividend (pct_dividend),
        .o_done     (pct_done),
        .o_quot     (pct_quot)
    );

    assign busy         = (r_state != S_IDLE);
    assign accept       = start && !busy;
    assign in_range     = CMP_W'(i_item.free_offset) < CMP_W'(POOL_BYTES);
    assign pct_dividend = PCT_W'(r_used) * PCT_W'(PCT_SCALE);

    // downward scan: length of the free run ending at the block just read
    assign run_next = (ram_rdata != '0) ? '0 : r_run + LEN_W'(1);
    assign rb_next  = (ram_rdata != '0) ? '0 : r_rb + RB_W'(BLOCK_BYTES);
    assign match    = (ram_rdata == '0)
                   && (CMP_W'(rb_next) >= CMP_W'(r_item.request_bytes));

    // the head entry of a free gives the run length
    assign cur_cnt    = (r_state == S_FREE_HEAD) ? ram_rdata : r_cnt;
    assign ptr_inc    = r_ptr + LEN_W'(1);
    assign ptr_dec    = r_ptr - LEN_W'(1);
    assign free_last  = (cur_cnt == LEN_W'(1)) || (ptr_inc == LEN_W'(BLOCK_COUNT));
    assign clear_last = (r_ptr == LEN_W'(BLOCK_COUNT - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_item.mode == MODE_FREE) begin
                        n_state = in_range ? S_OFS_DIV : S_PCT_GO;
                    end else begin
                        n_state = (i_item.request_bytes == '0) ? S_PCT_GO : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_state = S_FILL;
                end else if (r_ptr == '0) begin
                    n_state = S_PCT_GO;
                end
            end
            S_FILL: begin
                if (r_cnt == LEN_W'(1)) begin
                    n_state = S_PCT_GO;
                end
            end
            S_OFS_DIV: begin
                if (ofs_done) begin
                    n_state = S_FREE_HEAD;
                end
            end
            S_FREE_HEAD: begin
                if (cur_cnt == '0 || free_last) begin
                    n_state = S_PCT_GO;
                end else begin
                    n_state = S_FREE_RUN;
                end
            end
            S_FREE_RUN: begin
                if (free_last) begin
                    n_state = S_PCT_GO;
                end
            end
            S_PCT_GO: begin
                n_state = S_PCT;
            end
            S_PCT: begin
                if (pct_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // memory port and divider control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr[IDX_W-1:0];
        ram_wdata = '0;
        ram_raddr = ptr_inc[IDX_W-1:0];
        ofs_start = 1'b0;
        pct_start = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_IDLE: begin
                ram_raddr = IDX_W'(BLOCK_COUNT - 1);
                ofs_start = accept && (i_item.mode == MODE_FREE) && in_range;
            end
            S_SCAN: begin
                ram_raddr = ptr_dec[IDX_W-1:0];
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = r_need;
            end
            S_OFS_DIV: begin
                ram_raddr = IDX_W'(ofs_quot);
            end
            S_FREE_HEAD: begin
                ram_we = (cur_cnt != '0);
            end
            S_FREE_RUN: begin
                ram_we = 1'b1;
            end
            S_PCT_GO: begin
                pct_start = 1'b1;
            end
            S_PCT: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb begin
        n_ptr    = r_ptr;
        n_cnt    = r_cnt;
        n_need   = r_need;
        n_run    = r_run;
        n_used   = r_used;
        n_rb     = r_rb;
        n_item   = r_item;
        n_status = r_status;
        n_aofs   = r_aofs;
        n_result = r_result;
        n_valid  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                n_ptr = ptr_inc;
            end
            S_IDLE: begin
                if (accept) begin
                    n_item = i_item;
                    n_aofs = '0;
                    n_run  = '0;
                    n_rb   = '0;
                    n_ptr  = LEN_W'(BLOCK_COUNT - 1);
                    if (i_item.mode == MODE_FREE) begin
                        n_status = in_range ? ST_OK : ST_RANGE;
                    end else begin
                        n_status = ST_NO_FIT;
                    end
                end
            end
            S_SCAN: begin
                n_run = run_next;
                n_rb  = rb_next;
                if (match) begin
                    n_need   = run_next;
                    n_cnt    = run_next;
                    n_status = ST_OK;
                    n_aofs   = ALLOC_OFS_W'(r_ptr * BLOCK_BYTES);
                    n_used   = r_used + run_next;
                end else begin
                    n_ptr = ptr_dec;
                end
            end
            S_FILL: begin
                n_ptr = ptr_inc;
                n_cnt = r_cnt - LEN_W'(1);
            end
            S_OFS_DIV: begin
                if (ofs_done) begin
                    n_ptr = LEN_W'(ofs_quot);
                end
            end
            S_FREE_HEAD, S_FREE_RUN: begin
                if (cur_cnt != '0) begin
                    // a block already free within the span leaves the count alone
                    if (ram_rdata != '0 && r_used != '0) begin
                        n_used = r_used - LEN_W'(1);
                    end
                    n_ptr = ptr_inc;
                    n_cnt = cur_cnt - LEN_W'(1);
                end
            end
            S_PCT_GO: begin
                n_valid = 1'b0;
            end
            S_PCT: begin
                if (pct_done) begin
                    n_result.status       = r_status;
                    n_result.alloc_offset = r_aofs;
                    n_result.used_percent = pct_quot;
                    n_valid               = 1'b1;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_used  <= n_used;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_need   <= n_need;
        r_run    <= n_run;
        r_rb     <= n_rb;
        r_item   <= n_item;
        r_status <= n_status;
        r_aofs   <= n_aofs;
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `BMA_ASSERT(a_used_bound, i_clk, i_rst_n, r_used <= LEN_W'(BLOCK_COUNT), "used count past block count")
    `BMA_ASSERT(a_accept_busy, i_clk, i_rst_n, accept |=> busy, "accepted transaction left block idle")
    `BMA_ASSERT(a_valid_after_pct, i_clk, i_rst_n, o_valid |-> $past(r_state == S_PCT), "result strobe outside usage step")
    `BMA_ASSERT(a_fill_marks, i_clk, i_rst_n, (r_state == S_FILL) |-> (ram_we && ram_wdata != '0), "run fill wrote a free mark")

endmodule
